### rtl/fbfl_pkg.sv
// Shared package for the fixed-block free-list allocator.
// Holds the block size, request/response payload structs, codes and the
// command/status structs between controller and datapath. No dependencies.
package fbfl_pkg;

	localparam int unsigned BLOCK_BYTES    = 256;
	localparam int unsigned BLK_SHIFT      = $clog2(BLOCK_BYTES);
	localparam int unsigned MAX_BLOCKS_DEF = 256;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_SIZE  = 2'd2,
		ST_ADDR  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] req_size;
		logic [31:0] block_addr;
	} req_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic    load_req;
		logic    init_start;
		logic    walk_step;
		logic    link_read;
		logic    pop_commit;
		logic    push_commit;
		logic    resp_load;
		status_t resp_status;
		logic    resp_use_addr;
	} ctrl_t;

	typedef struct packed {
		op_t  op;
		logic size_bad;
		logic list_empty;
		logic addr_bad;
		logic pool_zero;
		logic walk_last;
		logic out_free;
	} stat_t;

endpackage

### rtl/fixed_block_free_list_allocator_core.sv
// Free, nop and rejected requests: result loaded from the execute state once the output is free.
// Alloc: a read of the link RAM first (execute state), result loaded from the wait state.
// Init: walks the link RAM one block per cycle over the saturated block count, then
// loads the result from the done state; one request in flight at a time.
// Reset: config zero, list empty; link RAM undefined and not cleared.
module fixed_block_free_list_allocator_core #(
	parameter int unsigned MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  fbfl_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output fbfl_pkg::rsp_t out_data,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [31:0]    cfg_data
);

	fbfl_pkg::ctrl_t cmd;
	fbfl_pkg::stat_t stat;

	fbfl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	fbfl_dp #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cmd      (cmd),
		.stat     (stat)
	);

	a_resp_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.resp_load |-> stat.out_free)
		else $error("response loaded over a stalled result");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_commit |-> !stat.list_empty)
		else $error("pop from an empty free list");

	a_out_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.resp_load))
		else $error("result shown without a response load");

endmodule

### rtl/fbfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module fbfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/fbfl_ctrl.sv
// Controller state machine of the free-list allocator.
// Depends on fbfl_pkg for the state enum and command/status structs.
module fbfl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  fbfl_pkg::stat_t stat,
	output fbfl_pkg::ctrl_t cmd
);

	fbfl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbfl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fbfl_pkg::S_IDLE: begin
				if (in_valid) state_d = fbfl_pkg::S_EXEC;
			end
			fbfl_pkg::S_EXEC: begin
				case (stat.op)
					fbfl_pkg::OP_INIT: begin
						state_d = stat.pool_zero ? fbfl_pkg::S_DONE : fbfl_pkg::S_WALK;
					end
					fbfl_pkg::OP_ALLOC: begin
						if (!stat.size_bad && !stat.list_empty) begin
							state_d = fbfl_pkg::S_WAIT;
						end else if (stat.out_free) begin
							state_d = fbfl_pkg::S_IDLE;
						end
					end
					default: begin
						if (stat.out_free) state_d = fbfl_pkg::S_IDLE;
					end
				endcase
			end
			fbfl_pkg::S_WAIT: begin
				if (stat.out_free) state_d = fbfl_pkg::S_IDLE;
			end
			fbfl_pkg::S_WALK: begin
				if (stat.walk_last) state_d = fbfl_pkg::S_DONE;
			end
			fbfl_pkg::S_DONE: begin
				if (stat.out_free) state_d = fbfl_pkg::S_IDLE;
			end
			default: state_d = fbfl_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.resp_status = fbfl_pkg::ST_OK;
		in_stall = (state_q != fbfl_pkg::S_IDLE);
		case (state_q)
			fbfl_pkg::S_IDLE: begin
				cmd.load_req = in_valid;
			end
			fbfl_pkg::S_EXEC: begin
				case (stat.op)
					fbfl_pkg::OP_INIT: begin
						cmd.init_start = 1'b1;
					end
					fbfl_pkg::OP_ALLOC: begin
						if (stat.size_bad) begin
							cmd.resp_load   = stat.out_free;
							cmd.resp_status = fbfl_pkg::ST_SIZE;
						end else if (stat.list_empty) begin
							cmd.resp_load   = stat.out_free;
							cmd.resp_status = fbfl_pkg::ST_EMPTY;
						end else begin
							cmd.link_read = 1'b1;
						end
					end
					fbfl_pkg::OP_FREE: begin
						cmd.resp_load = stat.out_free;
						if (stat.size_bad) begin
							cmd.resp_status = fbfl_pkg::ST_SIZE;
						end else if (stat.addr_bad) begin
							cmd.resp_status = fbfl_pkg::ST_ADDR;
						end else begin
							cmd.push_commit = stat.out_free;
						end
					end
					default: begin
						cmd.resp_load = stat.out_free;
					end
				endcase
			end
			fbfl_pkg::S_WAIT: begin
				// link data held in the RAM output register until the pop lands
				cmd.resp_load     = stat.out_free;
				cmd.pop_commit    = stat.out_free;
				cmd.resp_use_addr = 1'b1;
			end
			fbfl_pkg::S_WALK: begin
				cmd.walk_step = 1'b1;
			end
			fbfl_pkg::S_DONE: begin
				cmd.resp_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/fbfl_dp.sv
// Datapath of the free-list allocator: config, head/count/base registers,
// link store, address checks and output register.
// Depends on fbfl_pkg and fbfl_ram.
module fbfl_dp #(
	parameter int unsigned MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_data,
	input  fbfl_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output fbfl_pkg::rsp_t  out_data,
	input  fbfl_pkg::ctrl_t cmd,
	output fbfl_pkg::stat_t stat
);

	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned IW = $clog2(MAX_BLOCKS + 1);
	localparam logic [IW-1:0] NIL = IW'(MAX_BLOCKS);

	logic [31:0]    pool_base_q;
	logic [31:0]    pool_bytes_q;
	fbfl_pkg::req_t req_q;
	logic [IW-1:0]  head_q;
	logic [IW-1:0]  count_q;
	logic [31:0]    base_q;
	logic [IW-1:0]  walk_q;
	logic           out_valid_q;
	fbfl_pkg::rsp_t out_data_q;

	logic [31:0]   pool_blocks;
	logic [IW-1:0] init_count;
	logic [31:0]   off;
	logic [31:0]   free_idx;
	logic [IW-1:0] walk_next;
	logic [31:0]   alloc_addr;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [IW-1:0] ram_wdata;
	logic [IW-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= '0;
			pool_bytes_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index) pool_bytes_q <= cfg_data;
			else pool_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= in_data;
	end

	// saturated block count of the configured pool
	assign pool_blocks = pool_bytes_q >> fbfl_pkg::BLK_SHIFT;
	assign init_count  = (pool_blocks > 32'(MAX_BLOCKS)) ? NIL : pool_blocks[IW-1:0];

	assign off        = req_q.block_addr - base_q;
	assign free_idx   = off >> fbfl_pkg::BLK_SHIFT;
	assign walk_next  = walk_q + IW'(1);
	assign alloc_addr = base_q + (32'(head_q) << fbfl_pkg::BLK_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= NIL;
			count_q <= '0;
			base_q  <= '0;
			walk_q  <= '0;
		end else begin
			if (cmd.init_start) begin
				count_q <= init_count;
				base_q  <= pool_base_q;
				head_q  <= (init_count != '0) ? '0 : NIL;
				walk_q  <= '0;
			end else if (cmd.walk_step) begin
				walk_q <= walk_next;
			end else if (cmd.pop_commit) begin
				head_q <= ram_rdata;
			end else if (cmd.push_commit) begin
				head_q <= free_idx[IW-1:0];
			end
		end
	end

	assign ram_we    = cmd.walk_step || cmd.push_commit;
	assign ram_waddr = cmd.walk_step ? walk_q[AW-1:0] : free_idx[AW-1:0];
	assign ram_wdata = cmd.walk_step ? ((walk_next < count_q) ? walk_next : NIL) : head_q;

	fbfl_ram #(
		.WIDTH(IW),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.link_read),
		.raddr(head_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			out_data_q.addr   <= cmd.resp_use_addr ? alloc_addr : '0;
			out_data_q.status <= cmd.resp_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign stat.op         = fbfl_pkg::op_t'(req_q.op);
	assign stat.size_bad   = req_q.req_size > 32'(fbfl_pkg::BLOCK_BYTES);
	assign stat.list_empty = head_q >= NIL;
	assign stat.addr_bad   = (|off[fbfl_pkg::BLK_SHIFT-1:0]) || (free_idx >= 32'(count_q));
	assign stat.pool_zero  = (init_count == '0);
	assign stat.walk_last  = (walk_next == count_q);
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule
